[hdl/display_frame_deframer_responder_core_defines.svh]
// Assertion macros for the checker of the display frame deframer
`ifndef DISPLAY_FRAME_DEFRAMER_RESPONDER_CORE_DEFINES_SVH
`define DISPLAY_FRAME_DEFRAMER_RESPONDER_CORE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define DFDR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define DFDR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/dfdr_pkg.sv]
// Package of types and constants for the display frame deframer and responder
`timescale 1ns / 1ps
`default_nettype none

package dfdr_pkg;

   localparam logic [7:0] FRAME_HEAD   = 8'h55;
   localparam logic [7:0] REPLY_ZERO   = 8'h00;
   localparam logic [7:0] REPLY_FIXED  = 8'd100;
   localparam int         WIN_DEPTH    = 4;
   localparam logic [2:0] WIN_FULL     = 3'd4;
   // floor(level * 68 / 120) == (level * 37145) >> 16 for every 8-bit level
   localparam logic [15:0] LEVEL_RECIP = 16'd37145;

   // reply byte positions
   localparam logic [2:0] POS_HEAD  = 3'd0;
   localparam logic [2:0] POS_ZERO  = 3'd1;
   localparam logic [2:0] POS_SPDLO = 3'd2;
   localparam logic [2:0] POS_SPDHI = 3'd3;
   localparam logic [2:0] POS_FIXED = 3'd4;
   localparam logic [2:0] POS_LEVEL = 3'd5;
   localparam logic [2:0] POS_SUM   = 3'd6;

   typedef struct packed {
      logic [15:0] speed;
      logic [7:0]  level;
      logic [3:0]  mode;
      logic        reverse;
   } frame_rec_type;

endpackage

`default_nettype wire

[hdl/dfdr_front.sv]
// Front end: sliding window, frame match and reply record build
`timescale 1ns / 1ps
`default_nettype none

module dfdr_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   accept,
   input  wire logic [7:0]             rx_byte,
   input  wire logic [15:0]            speed_now,
   input  wire logic [7:0]             current_level,
   output logic                        push,
   output dfdr_pkg::frame_rec_type     push_data
);

   logic [7:0]  win_ff [dfdr_pkg::WIN_DEPTH];
   logic [7:0]  win_in [dfdr_pkg::WIN_DEPTH];
   logic [2:0]  fill_ff;
   logic [2:0]  fill_in;
   logic [7:0]  sum3;
   logic        match;
   logic [23:0] level_prod;

   assign sum3  = 8'(win_ff[1] + win_ff[2] + win_ff[3]);
   assign match = (fill_ff == dfdr_pkg::WIN_FULL) && (win_ff[0] == dfdr_pkg::FRAME_HEAD) &&
                  (rx_byte == sum3);
   assign push  = accept && match;

   assign level_prod = current_level * dfdr_pkg::LEVEL_RECIP;

   always_comb begin
      push_data.speed   = speed_now;
      push_data.level   = level_prod[23:16];
      push_data.mode    = win_ff[1][7:4];
      push_data.reverse = win_ff[3][0];
   end

   always_comb begin
      win_in  = win_ff;
      fill_in = fill_ff;
      if (accept) begin
         if (match) begin
            fill_in = '0;
         end else if (fill_ff == dfdr_pkg::WIN_FULL) begin
            win_in[0] = win_ff[1];
            win_in[1] = win_ff[2];
            win_in[2] = win_ff[3];
            win_in[3] = rx_byte;
         end else begin
            win_in[fill_ff[1:0]] = rx_byte;
            fill_in = 3'(fill_ff + 3'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

endmodule

`default_nettype wire

[hdl/dfdr_queue.sv]
// Short queue of matched-frame records between front and back end
`timescale 1ns / 1ps
`default_nettype none

module dfdr_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire dfdr_pkg::frame_rec_type push_data,
   input  wire logic                   pop,
   output logic                        full,
   output logic                        head_valid,
   output dfdr_pkg::frame_rec_type     head_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   dfdr_pkg::frame_rec_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

[hdl/dfdr_back.sv]
// Back end: reply byte sequencer with registered response stage
`timescale 1ns / 1ps
`default_nettype none

module dfdr_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   head_valid,
   input  wire dfdr_pkg::frame_rec_type head_data,
   output logic                        pop,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [7:0]                  rsp_reply_byte,
   output logic                        rsp_reply_last,
   output logic [3:0]                  rsp_drive_mode,
   output logic                        rsp_reverse_on
);

   logic       valid_ff, valid_in;
   logic [2:0] pos_ff, pos_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff;
   logic [3:0] mode_ff;
   logic       rev_ff;
   logic       advance;
   logic [7:0] spd_lo, spd_hi, check;

   assign advance = head_valid && (!valid_ff || !rsp_stall);
   assign pop     = advance && (pos_ff == dfdr_pkg::POS_SUM);

   assign spd_lo = head_data.speed[7:0];
   assign spd_hi = head_data.speed[15:8];
   assign check  = 8'(dfdr_pkg::REPLY_ZERO + spd_lo + spd_hi + dfdr_pkg::REPLY_FIXED +
                      head_data.level);

   always_comb begin
      unique case (pos_ff)
         dfdr_pkg::POS_HEAD:  byte_in = dfdr_pkg::FRAME_HEAD;
         dfdr_pkg::POS_ZERO:  byte_in = dfdr_pkg::REPLY_ZERO;
         dfdr_pkg::POS_SPDLO: byte_in = spd_lo;
         dfdr_pkg::POS_SPDHI: byte_in = spd_hi;
         dfdr_pkg::POS_FIXED: byte_in = dfdr_pkg::REPLY_FIXED;
         dfdr_pkg::POS_LEVEL: byte_in = head_data.level;
         default:             byte_in = check;
      endcase
   end

   always_comb begin
      pos_in   = pos_ff;
      valid_in = valid_ff;
      if (advance) begin
         valid_in = 1'b1;
         pos_in   = (pos_ff == dfdr_pkg::POS_SUM) ? dfdr_pkg::POS_HEAD : 3'(pos_ff + 3'd1);
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         byte_ff <= byte_in;
         last_ff <= (pos_ff == dfdr_pkg::POS_SUM);
         mode_ff <= head_data.mode;
         rev_ff  <= head_data.reverse;
      end
      if (reset) begin
         valid_ff <= 1'b0;
         pos_ff   <= dfdr_pkg::POS_HEAD;
      end else begin
         valid_ff <= valid_in;
         pos_ff   <= pos_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_reply_byte = byte_ff;
   assign rsp_reply_last = last_ff;
   assign rsp_drive_mode = mode_ff;
   assign rsp_reverse_on = rev_ff;

endmodule

`default_nettype wire

[hdl/display_frame_deframer_responder_core.sv]
// Top level of the display frame deframer and responder
`timescale 1ns / 1ps
`default_nettype none

// Takes one received byte per request, with the current speed and level, and
// looks for a five-byte frame (0x55, three payload bytes, their mod-256 sum).
// A request that does not complete a frame produces no response; a request
// that does completes it, empties the window and yields seven response bytes
// (0x55, 0x00, speed low, speed high, 100, level*68/120, checksum), the last
// one flagged, each carrying the frame's mode and reverse bits. The front end
// takes a request every cycle while its queue has room; the back end sends one
// response byte per cycle while rsp_stall is low and a frame is queued, and up
// to QUEUE_DEPTH matched frames wait between the two. No clearing pass after
// reset.
module display_frame_deframer_responder_core #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic [15:0] req_speed_now,
   input  wire logic [7:0]  req_current_level,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_reply_byte,
   output logic             rsp_reply_last,
   output logic [3:0]       rsp_drive_mode,
   output logic             rsp_reverse_on
);

   dfdr_pkg::frame_rec_type push_data;
   dfdr_pkg::frame_rec_type head_data;
   logic push, pop, full, head_valid, accept;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   dfdr_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .rx_byte       (req_rx_byte),
      .speed_now     (req_speed_now),
      .current_level (req_current_level),
      .push          (push),
      .push_data     (push_data)
   );

   dfdr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   dfdr_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_data      (head_data),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_reply_byte (rsp_reply_byte),
      .rsp_reply_last (rsp_reply_last),
      .rsp_drive_mode (rsp_drive_mode),
      .rsp_reverse_on (rsp_reverse_on)
   );

endmodule

`default_nettype wire

[hdl/dfdr_checker.sv]
// Port-level checker for the display frame deframer and responder, with bind
`timescale 1ns / 1ps
`default_nettype none
`include "display_frame_deframer_responder_core_defines.svh"

module dfdr_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [7:0]  rsp_reply_byte,
   input wire logic        rsp_reply_last,
   input wire logic [3:0]  rsp_drive_mode,
   input wire logic        rsp_reverse_on
);

   logic rsp_take_mid;

   assign rsp_take_mid = rsp_valid && !rsp_stall && !rsp_reply_last;

   `DFDR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_reply_byte) && $stable(rsp_reply_last), "stalled response changed")
   `DFDR_ASSERT_NEXT(a_frame_continues, clock, reset, rsp_take_mid, rsp_valid, "reply frame broken off before last byte")
   `DFDR_ASSERT_NEXT(a_frame_flags_steady, clock, reset, rsp_take_mid, $stable(rsp_drive_mode) && $stable(rsp_reverse_on), "mode or reverse changed inside a reply")

endmodule

bind display_frame_deframer_responder_core dfdr_checker u_dfdr_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_reply_byte (rsp_reply_byte),
   .rsp_reply_last (rsp_reply_last),
   .rsp_drive_mode (rsp_drive_mode),
   .rsp_reverse_on (rsp_reverse_on)
);

`default_nettype wire
